// ===== hdl/u8dec_pkg.sv =====
// u8dec_pkg: shared types and constants for the UTF-8 to UCS-2 decoder.
// Holds the request and result payload structs, the decode push bundle
// and the fixed constants. No dependencies.
package u8dec_pkg;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  localparam logic [7:0]  LimitReset = 8'd128;
  localparam logic [15:0] SpaceUnit  = 16'h0020;
  localparam logic [8:0]  TakenMax   = 9'd511;

  localparam logic [2:0] RegByteLimit = 3'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_terminator;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } dec_push_t;

endpackage

// ===== hdl/u8dec_core.sv =====
// u8dec_core: string state and single-pass decode of one held request.
// Produces up to two results per byte as a push bundle for the result queue.
// Depends on u8dec_pkg.
module u8dec_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  u8dec_pkg::in_item_t  item,
  input  logic [7:0]           byte_limit,
  output u8dec_pkg::dec_push_t push
);

  logic [8:0]  bytes_taken_r, bytes_taken_nxt;
  logic [1:0]  bytes_pending_r, bytes_pending_nxt;
  logic [15:0] partial_code_r, partial_code_nxt;
  logic        stopped_r, stopped_nxt;

  always_comb begin
    logic [8:0]  taken;
    logic [1:0]  pend;
    logic [15:0] part;
    logic        stop;
    logic [15:0] unit;
    logic [7:0]  b;

    b    = item.in_byte;
    taken = bytes_taken_r;
    pend  = bytes_pending_r;
    part  = partial_code_r;
    stop  = stopped_r;
    unit  = '0;
    push  = '0;

    if (item.string_start) begin
      taken = '0;
      pend  = '0;
      part  = '0;
      stop  = 1'b0;
    end

    if (!stop) begin
      if (pend == 2'd0 && b == 8'd0) begin
        stop = 1'b1;
        push.cnt = 2'd1;
        push.first = '{code_unit: 16'd0, is_terminator: 1'b1, last: 1'b1};
      end else begin
        if (taken != u8dec_pkg::TakenMax) begin
          taken = taken + 9'd1;
        end
        if (pend == 2'd0) begin
          priority casez (b)
            8'b0???????: part = {8'd0, b};
            8'b110?????: begin
              part = {11'd0, b[4:0]};
              pend = 2'd1;
            end
            8'b1110????: begin
              part = {12'd0, b[3:0]};
              pend = 2'd2;
            end
            8'b11110???: begin
              part = {13'd0, b[2:0]};
              pend = 2'd3;
            end
            default: part = {8'd0, b};
          endcase
        end else begin
          part = {part[9:0], b[5:0]};
          pend = pend - 2'd1;
        end
        if (pend == 2'd0) begin
          unit = (part < u8dec_pkg::SpaceUnit) ? u8dec_pkg::SpaceUnit : part;
          part = '0;
          if (taken >= {1'b0, byte_limit}) begin
            stop = 1'b1;
            push.cnt = 2'd2;
            push.first  = '{code_unit: unit, is_terminator: 1'b0, last: 1'b0};
            push.second = '{code_unit: 16'd0, is_terminator: 1'b1, last: 1'b1};
          end else begin
            push.cnt = 2'd1;
            push.first = '{code_unit: unit, is_terminator: 1'b0, last: 1'b1};
          end
        end
      end
    end

    if (!fire) begin
      push.cnt = 2'd0;
    end
    bytes_taken_nxt   = fire ? taken : bytes_taken_r;
    bytes_pending_nxt = fire ? pend  : bytes_pending_r;
    partial_code_nxt  = fire ? part  : partial_code_r;
    stopped_nxt       = fire ? stop  : stopped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_taken_r   <= '0;
      bytes_pending_r <= '0;
      partial_code_r  <= '0;
      stopped_r       <= 1'b0;
    end else begin
      bytes_taken_r   <= bytes_taken_nxt;
      bytes_pending_r <= bytes_pending_nxt;
      partial_code_r  <= partial_code_nxt;
      stopped_r       <= stopped_nxt;
    end
  end

endmodule

// ===== hdl/u8dec_res_fifo.sv =====
// u8dec_res_fifo: small result queue taking up to two results per cycle
// and handing one per cycle to the result channel while out_stall is low.
// Depends on u8dec_pkg.
module u8dec_res_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u8dec_pkg::dec_push_t  push,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u8dec_pkg::out_item_t  out_data
);

  u8dec_pkg::out_item_t               mem_r [u8dec_pkg::ResDepth];
  logic [u8dec_pkg::ResPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8dec_pkg::ResPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8dec_pkg::ResCntW-1:0] count_r, count_nxt;
  logic                          pop;
  logic [u8dec_pkg::ResPtrW-1:0] wr_ptr_inc;

  assign room       = count_r <= u8dec_pkg::ResCntW'(u8dec_pkg::ResDepth - 2);
  assign out_valid  = count_r != '0;
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  assign wr_ptr_inc = wr_ptr_r + u8dec_pkg::ResPtrW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + u8dec_pkg::ResPtrW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + u8dec_pkg::ResPtrW'(pop);
    count_nxt  = count_r + u8dec_pkg::ResCntW'(push.cnt) - u8dec_pkg::ResCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/utf8_to_ucs2_decoder.sv =====
// utf8_to_ucs2_decoder: top level with request register, byte_limit
// register on an APB-style port, decode core and result queue.
// Depends on u8dec_pkg, u8dec_core and u8dec_res_fifo.
//
// Usage: feed one UTF-8 byte per request on in_data (in_valid / in_stall),
// with string_start set on the first byte of a string. Results leave on
// out_data (out_valid / out_stall): one 16-bit code unit per completed
// character, a terminator after a zero byte or when byte_limit is reached.
// Lead bytes and all but the last continuation byte give no result; a byte may give up to two.
// An accepted request waits in the request register and is decoded once the queue has
// room; its results are registered in the queue before they are offered on out_data.
// Throughput: one request per cycle while in_stall is low; the result channel moves
// one result per cycle while out_stall is low, so bytes that give two results fill the
// four-entry result queue and the block raises in_stall while fewer than two entries are free.
// Reset (rst_n low, synchronous) empties the queue, clears the string state as
// if a string had just begun and sets byte_limit to 128.
// While the receiver holds out_stall the head result stays put; requests keep
// entering until the queue runs short of room.
// Write byte_limit at address 0 only while the block is idle.
module utf8_to_ucs2_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u8dec_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8dec_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic                 hold_valid_r, hold_valid_nxt;
  u8dec_pkg::in_item_t  hold_r;
  logic [7:0]           byte_limit_r, byte_limit_nxt;
  logic                 room;
  logic                 fire;
  logic                 in_take;
  logic                 cfg_wr;
  u8dec_pkg::dec_push_t push;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr == u8dec_pkg::RegByteLimit) ? {24'd0, byte_limit_r} : 32'd0;

  assign fire     = hold_valid_r && room;
  assign in_stall = hold_valid_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = in_take || (hold_valid_r && !fire);
    byte_limit_nxt = byte_limit_r;
    if (cfg_wr && paddr[2] == u8dec_pkg::RegByteLimit[2]) begin
      byte_limit_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      byte_limit_r <= u8dec_pkg::LimitReset;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      byte_limit_r <= byte_limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  u8dec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (hold_r),
    .byte_limit (byte_limit_r),
    .push       (push)
  );

  u8dec_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_valid_r)
    else $error("input stalled with empty request register");

  a_term_is_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_terminator) |->
      (out_data.last && out_data.code_unit == 16'd0))
    else $error("terminator result not last or not zero");

  a_push_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> fire)
    else $error("result pushed without a decoded request");

  a_unit_not_control: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_terminator) |->
      (out_data.code_unit >= u8dec_pkg::SpaceUnit))
    else $error("code unit below space escaped");

endmodule
